// ----- design/wzpd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed z-score peak detector package
// Shared widths, state encodings and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package wzpd_pkg;

  localparam int DEPTH      = 64;
  localparam int PRICE_BITS = 32;
  localparam int TIME_BITS  = 48;
  localparam int Z_BITS     = 12;
  localparam int IDX_BITS   = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);
  localparam int SUM_BITS   = PRICE_BITS + IDX_BITS + 1;
  localparam int SSD_BITS   = 2 * PRICE_BITS + IDX_BITS + 1;
  localparam int ROOT_BITS  = (SSD_BITS + 1) / 2;

  localparam logic [TIME_BITS-1:0] WINDOW_RESET = TIME_BITS'(1000);
  localparam logic [Z_BITS-1:0]    Z_RESET      = Z_BITS'(502);

  // Verdict codes.
  localparam logic [1:0] VERDICT_NONE   = 2'd0;
  localparam logic [1:0] VERDICT_PEAK   = 2'd1;
  localparam logic [1:0] VERDICT_VALLEY = 2'd2;
  localparam logic [1:0] VERDICT_SHORT  = 2'd3;

  // Register addresses.
  localparam logic [3:0] ADDR_WINDOW = 4'h0;
  localparam logic [3:0] ADDR_ZSCALE = 4'h8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVICT_RD,
    ST_EVICT_CHK,
    ST_APPEND,
    ST_SUM,
    ST_MEAN,
    ST_SSD,
    ST_VAR,
    ST_SQRT,
    ST_BAND
  } wzpd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the input item
    logic evict_rd;   // read the time of the oldest entry
    logic evict_pop;  // drop the oldest entry
    logic append;     // write the new entry
    logic sum_start;  // clear index and sum
    logic sum_step;   // accumulate one entry
    logic div_start;  // start a division
    logic div_step;   // one quotient bit
    logic div_var;    // divide the squared-deviation sum instead of the sum
    logic ssd_start;
    logic ssd_step;
    logic sqrt_start;
    logic sqrt_step;
    logic band;       // compute band and verdict
  } wzpd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic evict_hit;  // oldest entry lies outside the window
    logic scan_done;  // index reached the history size
    logic div_done;
    logic sqrt_done;
    logic short_hist; // fewer than two earlier entries
  } wzpd_sts_t;

endpackage
`default_nettype wire

// ----- design/wzpd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed z-score peak detector controller
// Sequences eviction, append, the two store passes, division and square root.
// ----------------------------------------------------------------------------
module wzpd_ctrl
  import wzpd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire wzpd_sts_t sts,
  output wzpd_cmd_t      cmd
);

  wzpd_state_t state, state_next;
  logic        var_phase, var_phase_next;
  logic        out_full, out_full_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      var_phase <= 1'b0;
      out_full  <= 1'b0;
    end else begin
      state     <= state_next;
      var_phase <= var_phase_next;
      out_full  <= out_full_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    var_phase_next = var_phase;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid      = out_full;
    out_full_next  = out_full;
    cmd.div_var    = var_phase;
    // The result register empties when its transfer completes.
    if (out_full && out_ready) begin
      out_full_next = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EVICT_RD;
        end
      end
      ST_EVICT_RD: begin
        cmd.evict_rd = 1'b1;
        state_next   = ST_EVICT_CHK;
      end
      ST_EVICT_CHK: begin
        if (sts.evict_hit) begin
          cmd.evict_pop = 1'b1;
          state_next    = ST_EVICT_RD;
        end else begin
          state_next = ST_APPEND;
        end
      end
      ST_APPEND: begin
        cmd.append    = 1'b1;
        cmd.sum_start = 1'b1;
        state_next    = ST_SUM;
      end
      ST_SUM: begin
        if (sts.short_hist) begin
          state_next = ST_BAND;
        end else if (sts.scan_done) begin
          cmd.div_start  = 1'b1;
          var_phase_next = 1'b0;
          cmd.div_var    = 1'b0;
          state_next     = ST_MEAN;
        end else begin
          cmd.sum_step = 1'b1;
        end
      end
      ST_MEAN: begin
        if (sts.div_done) begin
          cmd.ssd_start = 1'b1;
          state_next    = ST_SSD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_SSD: begin
        if (sts.scan_done) begin
          cmd.div_start  = 1'b1;
          var_phase_next = 1'b1;
          cmd.div_var    = 1'b1;
          state_next     = ST_VAR;
        end else begin
          cmd.ssd_step = 1'b1;
        end
      end
      ST_VAR: begin
        if (sts.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_next     = ST_SQRT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_SQRT: begin
        if (sts.sqrt_done) begin
          state_next = ST_BAND;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      // Load the result register once it is free or being emptied.
      ST_BAND: begin
        if (!out_full || out_ready) begin
          cmd.band      = 1'b1;
          out_full_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- design/wzpd_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed z-score peak detector datapath
// Ring store, accumulators, restoring divider, bitwise square root and band.
// ----------------------------------------------------------------------------
module wzpd_dp
  import wzpd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire wzpd_cmd_t             cmd,
  output wzpd_sts_t                  sts,
  input  wire logic [PRICE_BITS-1:0] new_price,
  input  wire logic [TIME_BITS-1:0]  new_time,
  input  wire logic [TIME_BITS-1:0]  window_time,
  input  wire logic [Z_BITS-1:0]     z_scale,
  output logic [1:0]                 verdict,
  output logic [PRICE_BITS-1:0]      window_mean,
  output logic [PRICE_BITS-1:0]      std_dev,
  output logic [PRICE_BITS-1:0]      band_low,
  output logic [PRICE_BITS-1:0]      band_high,
  output logic [CNT_BITS-1:0]        history_count
);

  localparam int SQ_BITS  = 2 * PRICE_BITS;
  localparam int DIV_BITS = SSD_BITS;
  localparam int SC_BITS  = Z_BITS + ROOT_BITS;
  localparam logic [PRICE_BITS-1:0] PRICE_MAX = '1;

  // Ring store memories.
  logic [PRICE_BITS-1:0] price_mem [DEPTH];
  logic [TIME_BITS-1:0]  time_mem  [DEPTH];

  logic [PRICE_BITS-1:0] price_q;
  logic [TIME_BITS-1:0]  time_q;
  logic [IDX_BITS-1:0]   oldest_slot;
  logic [CNT_BITS-1:0]   entry_count;
  logic [TIME_BITS-1:0]  oldest_time;
  logic [PRICE_BITS-1:0] rd_price;
  logic                  rd_price_ok;
  logic [CNT_BITS-1:0]   scan_idx;
  logic [CNT_BITS-1:0]   hist_n;
  logic [SUM_BITS-1:0]   sum;
  logic [SSD_BITS-1:0]   ssd;
  logic [PRICE_BITS-1:0] mean;
  logic [SQ_BITS-1:0]    sq_prod;
  logic                  sq_ok;

  logic [DIV_BITS-1:0]   div_quo;
  logic [CNT_BITS-1:0]   div_rem;
  logic [$clog2(DIV_BITS+1)-1:0] div_cnt;
  logic [CNT_BITS-1:0]   div_den;

  logic [ROOT_BITS-1:0]  root;
  logic [SSD_BITS-1:0]   sq_val;
  logic [$clog2(ROOT_BITS+1)-1:0] sqrt_cnt;
  logic [2*ROOT_BITS-1:0] cand_sq;
  logic [ROOT_BITS-1:0]  cand;

  logic [IDX_BITS-1:0]   app_slot;
  logic [IDX_BITS-1:0]   rd_slot;
  logic                  full;
  logic                  evict_ok;
  logic [TIME_BITS-1:0]  limit;

  assign full     = (entry_count == CNT_BITS'(DEPTH));
  assign limit    = time_q - window_time;
  assign evict_ok = (time_q >= window_time) && (entry_count != '0);
  assign app_slot = full ? oldest_slot : oldest_slot + entry_count[IDX_BITS-1:0];
  assign rd_slot  = oldest_slot + scan_idx[IDX_BITS-1:0];

  assign sts.evict_hit  = evict_ok && (oldest_time <= limit);
  assign sts.scan_done  = (scan_idx == hist_n) && !rd_price_ok && !sq_ok;
  assign sts.div_done   = (div_cnt == '0);
  assign sts.sqrt_done  = (sqrt_cnt == '0);
  assign sts.short_hist = (hist_n < CNT_BITS'(2));

  // Store writes and reads.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      price_mem[app_slot] <= price_q;
      time_mem[app_slot]  <= time_q;
    end
    if (cmd.evict_rd) begin
      oldest_time <= time_mem[oldest_slot];
    end
    rd_price <= price_mem[rd_slot];
  end

  // Ring pointers and input capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_slot <= '0;
      entry_count <= '0;
    end else if (cmd.evict_pop) begin
      oldest_slot <= oldest_slot + 1'b1;
      entry_count <= entry_count - 1'b1;
    end else if (cmd.append) begin
      if (full) begin
        oldest_slot <= oldest_slot + 1'b1;
      end else begin
        entry_count <= entry_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      price_q <= new_price;
      time_q  <= new_time;
    end
    if (cmd.append) begin
      hist_n <= full ? CNT_BITS'(DEPTH - 1) : entry_count;
    end
  end

  // Store scans: issue a read per cycle, add the registered read or square.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_price_ok <= 1'b0;
      sq_ok       <= 1'b0;
    end else begin
      rd_price_ok <= (cmd.sum_step || cmd.ssd_step) && (scan_idx != hist_n);
      sq_ok       <= rd_price_ok && !cmd.sum_step && (scan_idx != '0 || cmd.ssd_step);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_start || cmd.ssd_start) begin
      scan_idx <= '0;
    end else if ((cmd.sum_step || cmd.ssd_step) && scan_idx != hist_n) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (cmd.sum_start) begin
      sum <= '0;
    end else if (rd_price_ok && cmd.sum_step) begin
      sum <= sum + SUM_BITS'(rd_price);
    end
    // Square the absolute deviation, then accumulate the registered product.
    if (rd_price_ok) begin
      sq_prod <= (rd_price >= mean ? rd_price - mean : mean - rd_price) *
                 (rd_price >= mean ? rd_price - mean : mean - rd_price);
    end
    if (cmd.ssd_start) begin
      ssd <= '0;
    end else if (sq_ok) begin
      ssd <= ssd + SSD_BITS'(sq_prod);
    end
  end

  // Restoring divider: one quotient bit per cycle.
  logic [CNT_BITS:0] div_trial;
  assign div_trial = {div_rem, div_quo[DIV_BITS-1]} - {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= ($clog2(DIV_BITS+1))'(DIV_BITS);
    end else if (cmd.div_step && div_cnt != '0) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem <= '0;
      div_quo <= cmd.div_var ? ssd : DIV_BITS'(sum);
      div_den <= cmd.div_var ? hist_n - 1'b1 : hist_n;
    end else if (cmd.div_step && div_cnt != '0) begin
      if (!div_trial[CNT_BITS]) begin
        div_rem <= div_trial[CNT_BITS-1:0];
        div_quo <= {div_quo[DIV_BITS-2:0], 1'b1};
      end else begin
        div_rem <= {div_rem[CNT_BITS-2:0], div_quo[DIV_BITS-1]};
        div_quo <= {div_quo[DIV_BITS-2:0], 1'b0};
      end
    end
    if (cmd.ssd_start) begin
      mean <= div_quo[PRICE_BITS-1:0];
    end
  end

  // Bitwise square root: try one result bit per cycle, most significant first.
  assign cand    = root | (ROOT_BITS'(1) << (sqrt_cnt - 1'b1));
  assign cand_sq = cand * cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      sqrt_cnt <= '0;
    end else if (cmd.sqrt_start) begin
      sqrt_cnt <= ($clog2(ROOT_BITS+1))'(ROOT_BITS);
    end else if (cmd.sqrt_step && sqrt_cnt != '0) begin
      sqrt_cnt <= sqrt_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      root   <= '0;
      sq_val <= div_quo;
    end else if (cmd.sqrt_step && sqrt_cnt != '0) begin
      if (cand_sq <= (2*ROOT_BITS)'(sq_val)) begin
        root <= cand;
      end
    end
  end

  // Band and verdict.
  logic [SC_BITS-1:0]    scaled;
  logic [SC_BITS-8-1:0]  dev;
  logic [SC_BITS-8:0]    hi_sum;
  assign scaled = SC_BITS'(z_scale) * SC_BITS'(root);
  assign dev    = scaled[SC_BITS-1:8];
  assign hi_sum = (SC_BITS-7)'(mean) + (SC_BITS-7)'(dev);

  always_ff @(posedge clk) begin
    if (cmd.band) begin
      history_count <= hist_n;
      if (hist_n < CNT_BITS'(2)) begin
        verdict     <= VERDICT_SHORT;
        window_mean <= '0;
        std_dev     <= '0;
        band_low    <= '0;
        band_high   <= '0;
      end else begin
        window_mean <= mean;
        std_dev     <= root[PRICE_BITS-1:0];
        band_low    <= ((SC_BITS-8)'(mean) <= dev) ? '0 :
                       PRICE_BITS'((SC_BITS-8)'(mean) - dev);
        band_high   <= (hi_sum > (SC_BITS-7)'(PRICE_MAX)) ? PRICE_MAX :
                       hi_sum[PRICE_BITS-1:0];
        if ((SC_BITS-8)'(mean) > dev &&
            (SC_BITS-8)'(price_q) < (SC_BITS-8)'(mean) - dev) begin
          verdict <= VERDICT_VALLEY;
        end else if ((SC_BITS-7)'(price_q) > hi_sum) begin
          verdict <= VERDICT_PEAK;
        end else begin
          verdict <= VERDICT_NONE;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/windowed_zscore_peak_detector_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed z-score peak detector
// Keeps a time window of up to 64 prices and classifies each new price.
// ----------------------------------------------------------------------------
// Usage: an item (new_price, new_time) transfers on the input channel when
// in_valid and in_ready are high. The block evicts aged entries one at a
// time, appends the item, sums the history, divides for the mean, sums the
// squared deviations, divides for the variance and takes a bitwise square
// root, then loads one result into the output register. With a history of
// fewer than two entries it skips the statistics and goes to the band step.
// Each of the two divisions takes 71 steps and the square root 36; the store
// scans read one entry per cycle. One item is in work at a time and in_ready
// is high only while idle, so a new item is taken only once the last result
// is loaded. A stalled receiver holds the result on the output ports; the
// next item is still taken and processed, and waits before its band step
// until the held result transfers.
// Reset empties the store and sets window_time to 1000 and z_scale to 502.
// Registers: window_time at byte 0, z_scale at byte 8 (64-bit data).
// ----------------------------------------------------------------------------
module windowed_zscore_peak_detector_unit
  import wzpd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [3:0]            paddr,
  input  wire logic [63:0]           pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [PRICE_BITS-1:0] new_price,
  input  wire logic [TIME_BITS-1:0]  new_time,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 verdict,
  output logic [PRICE_BITS-1:0]      window_mean,
  output logic [PRICE_BITS-1:0]      std_dev,
  output logic [PRICE_BITS-1:0]      band_low,
  output logic [PRICE_BITS-1:0]      band_high,
  output logic [CNT_BITS-1:0]        history_count
);

  logic [TIME_BITS-1:0] window_time;
  logic [Z_BITS-1:0]    z_scale;
  wzpd_cmd_t            cmd;
  wzpd_sts_t            sts;

  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_time <= WINDOW_RESET;
      z_scale     <= Z_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        ADDR_WINDOW: window_time <= pwdata[TIME_BITS-1:0];
        ADDR_ZSCALE: z_scale     <= pwdata[Z_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr)
      ADDR_WINDOW: prdata = 64'(window_time);
      ADDR_ZSCALE: prdata = 64'(z_scale);
      default:     prdata = '0;
    endcase
  end

  wzpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wzpd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .new_price     (new_price),
    .new_time      (new_time),
    .window_time   (window_time),
    .z_scale       (z_scale),
    .verdict       (verdict),
    .window_mean   (window_mean),
    .std_dev       (std_dev),
    .band_low      (band_low),
    .band_high     (band_high),
    .history_count (history_count)
  );

  // A stalled result stays valid and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
    $stable({verdict, window_mean, std_dev, band_low, band_high, history_count}))
    else $error("result changed while stalled");

  // A short history always reports zero statistics.
  a_short: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == VERDICT_SHORT |-> window_mean == '0 && std_dev == '0)
    else $error("short history with statistics");

  // The low band never exceeds the high band for a full result.
  a_band: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != VERDICT_SHORT |-> band_low <= band_high)
    else $error("band order");

endmodule
`default_nettype wire
